@@ rtl/rwp_pkg.sv @@
// ---------------------------------------------------------------------------
// rwp_pkg: shared types and constants of the RIFF/WAVE stream parser
// Transaction payloads, controller phases, result and error codes, and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package rwp_pkg;

	localparam logic [31:0] ID_RIFF = 32'h5249_4646;
	localparam logic [31:0] ID_WAVE = 32'h5741_5645;
	localparam logic [31:0] ID_FMT  = 32'h666D_7420;
	localparam logic [31:0] ID_DATA = 32'h6461_7461;

	localparam logic [15:0] PCM_TAG  = 16'd1;
	localparam logic [31:0] FMT_BODY = 32'd16;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_FORMAT = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;
	localparam logic [1:0] KIND_END    = 2'd3;

	localparam logic [2:0] ERR_RIFF  = 3'd0;
	localparam logic [2:0] ERR_WAVE  = 3'd1;
	localparam logic [2:0] ERR_SHORT = 3'd2;
	localparam logic [2:0] ERR_PCM   = 3'd3;
	localparam logic [2:0] ERR_BITS  = 3'd4;
	localparam logic [2:0] ERR_ALIGN = 3'd5;
	localparam logic [2:0] ERR_DSIZE = 3'd6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} in_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic signed [15:0] sample_value;
		logic               channel_index;
		logic [2:0]         error_code;
		logic [15:0]        channel_count;
		logic [15:0]        sample_bits;
		logic [31:0]        sample_rate;
		logic [31:0]        data_length;
	} out_t;

	typedef enum logic [3:0] {
		PH_RIFF,
		PH_WAVE,
		PH_FMT_HDR,
		PH_SKIP_FMT,
		PH_FMT_BODY,
		PH_FMT_EXTRA,
		PH_DATA_HDR,
		PH_DIV_WAIT,
		PH_SKIP_DATA,
		PH_SAMPLES,
		PH_END,
		PH_IDLE,
		PH_ERROR
	} phase_t;

	typedef struct packed {
		logic       restart;
		logic       hdr;
		logic       wave;
		logic       skip;
		logic       fmt_clear;
		logic       fmt_body;
		logic       div_start;
		logic       load_data;
		logic       sample;
		logic       emit;
		logic [1:0] kind;
		logic [2:0] code;
	} cmd_t;

	typedef struct packed {
		logic hdr_done;
		logic wave_done;
		logic wave_ok;
		logic id_riff;
		logic id_fmt;
		logic id_data;
		logic len_lt16;
		logic len_nz;
		logic cl_one;
		logic body_done;
		logic tag_ok;
		logic cl_is16;
		logic bits_ok;
		logic align_ok;
		logic div_busy;
		logic rem_zero;
		logic cl_nz;
		logic samp_emit;
		logic data_last;
	} stat_t;

endpackage

@@ rtl/riff_wave_stream_parser.sv @@
// ---------------------------------------------------------------------------
// riff_wave_stream_parser: byte-serial RIFF/WAVE PCM parser
// Checks the file header, reads the fmt chunk, finds the data chunk and
// turns data bytes into samples for channels 0 and 1.
// ---------------------------------------------------------------------------
// One byte is taken per cycle in every phase, with two exceptions. After the
// last header byte of the data chunk the input stalls while the chunk size
// is checked against the frame alignment by a restoring remainder unit
// that retires one bit per cycle. A result waits in a single output
// register, and the input also stalls while that register is full and
// stalled. At most one result per byte: a sample, the format report, an
// error (sticky until start_of_file) or the end of data, which comes on the
// first byte after the data chunk. Chunks are skipped by exact size, with
// no pad byte.
module riff_wave_stream_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  rwp_pkg::in_t  in_item,
	output logic          out_valid,
	input  logic          out_stall,
	output rwp_pkg::out_t out_item
);

	rwp_pkg::cmd_t  cmd;
	rwp_pkg::stat_t st;
	rwp_pkg::out_t  res;
	rwp_pkg::out_t  res_q;
	logic           res_vld_q;
	logic           out_free;

	// output slot is free when empty or being drained this cycle
	assign out_free = !res_vld_q || !out_stall;

	rwp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sof      (in_item.start_of_file),
		.out_free (out_free),
		.st       (st),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	rwp_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_item),
		.cmd    (cmd),
		.st     (st),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			res_vld_q <= 1'b1;
		end else if (!out_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q <= res;
		end
	end

	assign out_valid = res_vld_q;
	assign out_item  = res_q;

	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result written into a full output slot");

	// size check starts the remainder unit
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> st.div_busy)
		else $error("remainder unit did not start");

	// no byte taken while the remainder unit runs
	a_div_stall: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_busy |-> in_stall)
		else $error("input accepted during size check");

endmodule

@@ rtl/rwp_rem.sv @@
// ---------------------------------------------------------------------------
// rwp_rem: iterative remainder unit
// Restoring remainder of a 32-bit dividend by a 16-bit divisor, one
// quotient bit per cycle. Flags a zero remainder when done.
// ---------------------------------------------------------------------------
module rwp_rem (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic        rem_zero
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [31:0] dvd_q;
	logic [15:0] div_q;
	logic [15:0] rem_q;
	logic [16:0] trial;
	logic [16:0] diff;

	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			// remainder stays below the divisor, so 16 bits hold it
			rem_q <= (trial >= {1'b0, div_q}) ? diff[15:0] : trial[15:0];
		end
	end

	assign busy     = busy_q;
	assign rem_zero = (rem_q == 16'd0);

endmodule

@@ rtl/rwp_dp.sv @@
// ---------------------------------------------------------------------------
// rwp_dp: parser datapath
// Header collection, format fields, chunk and data counters, sample
// assembly and result payload. Acts on controller commands only.
// ---------------------------------------------------------------------------
module rwp_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  rwp_pkg::in_t  item,
	input  rwp_pkg::cmd_t cmd,
	output rwp_pkg::stat_t st,
	output rwp_pkg::out_t res
);

	localparam logic [31:0] FMT_BODY_L = rwp_pkg::FMT_BODY;

	logic [4:0]  cnt_q;
	logic [31:0] id_q;
	logic [31:0] cl_q;
	logic [15:0] tag_q;
	logic [15:0] chan_q;
	logic [31:0] rate_q;
	logic [15:0] bits_q;
	logic [15:0] align_q;
	logic [31:0] dr_q;
	logic [15:0] pos_q;
	logic [7:0]  low_q;

	logic [4:0]  cnt;
	logic [7:0]  b;
	logic [31:0] id_nx;
	logic [31:0] len_nx;
	logic [31:0] b_sh;
	logic [15:0] bits_nx;
	logic [16:0] pos_inc;
	logic        div_busy;
	logic        rem_zero;
	logic        s16_emit;

	assign b     = item.data_byte;
	assign cnt   = cmd.restart ? 5'd0 : cnt_q;
	assign id_nx = {id_q[23:0], b};
	assign b_sh  = {24'd0, b} << {cnt[1:0], 3'b000};

	always_comb begin
		if (cnt == 5'd0) begin
			len_nx = '0;
		end else if (cnt >= 5'd4) begin
			len_nx = cl_q | b_sh;
		end else begin
			len_nx = cl_q;
		end
	end

	always_comb begin
		bits_nx = bits_q;
		if (cmd.fmt_body && cnt_q == 5'd14) begin
			bits_nx = bits_q | {8'd0, b};
		end else if (cmd.fmt_body && cnt_q == 5'd15) begin
			bits_nx = bits_q | {b, 8'd0};
		end
	end

	assign pos_inc  = {1'b0, pos_q} + 17'd1;
	assign s16_emit = pos_q[0] && (pos_q < 16'd4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.hdr) begin
			cnt_q <= (cnt == 5'd7) ? 5'd0 : cnt + 5'd1;
		end else if (cmd.wave) begin
			cnt_q <= (cnt == 5'd3) ? 5'd0 : cnt + 5'd1;
		end else if (cmd.fmt_body) begin
			cnt_q <= (cnt == 5'd15) ? 5'd0 : cnt + 5'd1;
		end else if (cmd.restart) begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.hdr && cnt < 5'd4) || cmd.wave) begin
			id_q <= id_nx;
		end
		if (cmd.hdr) begin
			cl_q <= len_nx;
		end else if (cmd.skip) begin
			cl_q <= cl_q - 32'd1;
		end else if (cmd.fmt_body && cnt == 5'd15) begin
			cl_q <= cl_q - FMT_BODY_L;
		end
		if (cmd.fmt_clear) begin
			tag_q   <= '0;
			chan_q  <= '0;
			rate_q  <= '0;
			bits_q  <= '0;
			align_q <= '0;
		end else if (cmd.fmt_body) begin
			case (cnt[3:0])
				4'd0:    tag_q   <= tag_q | {8'd0, b};
				4'd1:    tag_q   <= tag_q | {b, 8'd0};
				4'd2:    chan_q  <= chan_q | {8'd0, b};
				4'd3:    chan_q  <= chan_q | {b, 8'd0};
				4'd4:    rate_q  <= rate_q | {24'd0, b};
				4'd5:    rate_q  <= rate_q | {16'd0, b, 8'd0};
				4'd6:    rate_q  <= rate_q | {8'd0, b, 16'd0};
				4'd7:    rate_q  <= rate_q | {b, 24'd0};
				4'd12:   align_q <= align_q | {8'd0, b};
				4'd13:   align_q <= align_q | {b, 8'd0};
				4'd14,
				4'd15:   bits_q  <= bits_nx;
				default: ;
			endcase
		end
		if (cmd.load_data) begin
			dr_q  <= cl_q;
			pos_q <= '0;
		end else if (cmd.sample) begin
			dr_q  <= dr_q - 32'd1;
			pos_q <= (pos_inc >= {1'b0, align_q}) ? 16'd0 : pos_inc[15:0];
			if (!pos_q[0]) begin
				low_q <= b;
			end
		end
	end

	rwp_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (len_nx),
		.divisor  (align_q),
		.busy     (div_busy),
		.rem_zero (rem_zero)
	);

	always_comb begin
		st.hdr_done  = (cnt == 5'd7);
		st.wave_done = (cnt == 5'd3);
		st.wave_ok   = (id_nx == rwp_pkg::ID_WAVE);
		st.id_riff   = (id_q == rwp_pkg::ID_RIFF);
		st.id_fmt    = (id_q == rwp_pkg::ID_FMT);
		st.id_data   = (id_q == rwp_pkg::ID_DATA);
		st.len_lt16  = (len_nx < FMT_BODY_L);
		st.len_nz    = (len_nx != 32'd0);
		st.cl_one    = (cl_q == 32'd1);
		st.body_done = (cnt == 5'd15);
		st.tag_ok    = (tag_q == rwp_pkg::PCM_TAG);
		st.cl_is16   = (cl_q == FMT_BODY_L);
		st.bits_ok   = (bits_nx == 16'd8) || (bits_nx == 16'd16);
		// bits is 8 or 16 here, so align*8 == channels*bits reduces to a compare
		st.align_ok  = (align_q != 16'd0) &&
			((bits_nx == 16'd8) ? (align_q == chan_q)
				: ({1'b0, align_q} == {chan_q, 1'b0}));
		st.div_busy  = div_busy;
		st.rem_zero  = rem_zero;
		st.cl_nz     = (cl_q != 32'd0);
		st.samp_emit = (bits_q == 16'd8) ? (pos_q < 16'd2) : s16_emit;
		st.data_last = (dr_q == 32'd1);
	end

	always_comb begin
		res               = '0;
		res.result_kind   = cmd.kind;
		case (cmd.kind)
			rwp_pkg::KIND_SAMPLE: begin
				if (bits_q == 16'd8) begin
					res.sample_value  = {8'd0, b};
					res.channel_index = pos_q[0];
				end else begin
					res.sample_value  = {b, low_q};
					res.channel_index = pos_q[1];
				end
			end
			rwp_pkg::KIND_FORMAT: begin
				res.channel_count = chan_q;
				res.sample_bits   = bits_q;
				res.sample_rate   = rate_q;
				res.data_length   = cl_q;
			end
			rwp_pkg::KIND_ERROR: begin
				res.error_code = cmd.code;
			end
			rwp_pkg::KIND_END: begin
				res.data_length = cl_q;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/rwp_ctrl.sv @@
// ---------------------------------------------------------------------------
// rwp_ctrl: parser controller
// Phase state machine. Decides per accepted byte what the datapath does
// and which result, if any, goes out. Holds input during the size check.
// ---------------------------------------------------------------------------
module rwp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           sof,
	input  logic           out_free,
	input  rwp_pkg::stat_t st,
	output logic           in_stall,
	output rwp_pkg::cmd_t  cmd
);

	rwp_pkg::phase_t ph_q, ph_nx, ph;
	logic            acc;

	assign in_stall = (ph_q == rwp_pkg::PH_DIV_WAIT) || !out_free;
	assign acc      = in_valid && !in_stall;
	assign ph       = (acc && sof) ? rwp_pkg::PH_RIFF : ph_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= rwp_pkg::PH_RIFF;
		end else begin
			ph_q <= ph_nx;
		end
	end

	always_comb begin
		ph_nx       = ph_q;
		cmd         = '0;
		cmd.restart = acc && sof;
		if (acc) begin
			ph_nx = ph;
			case (ph)
				rwp_pkg::PH_RIFF: begin
					cmd.hdr = 1'b1;
					if (st.hdr_done) begin
						if (!st.id_riff) begin
							cmd.emit = 1'b1;
							cmd.kind = rwp_pkg::KIND_ERROR;
							cmd.code = rwp_pkg::ERR_RIFF;
							ph_nx    = rwp_pkg::PH_ERROR;
						end else begin
							ph_nx = rwp_pkg::PH_WAVE;
						end
					end
				end
				rwp_pkg::PH_WAVE: begin
					cmd.wave = 1'b1;
					if (st.wave_done) begin
						if (!st.wave_ok) begin
							cmd.emit = 1'b1;
							cmd.kind = rwp_pkg::KIND_ERROR;
							cmd.code = rwp_pkg::ERR_WAVE;
							ph_nx    = rwp_pkg::PH_ERROR;
						end else begin
							ph_nx = rwp_pkg::PH_FMT_HDR;
						end
					end
				end
				rwp_pkg::PH_FMT_HDR: begin
					cmd.hdr = 1'b1;
					if (st.hdr_done) begin
						if (st.id_fmt) begin
							if (st.len_lt16) begin
								cmd.emit = 1'b1;
								cmd.kind = rwp_pkg::KIND_ERROR;
								cmd.code = rwp_pkg::ERR_SHORT;
								ph_nx    = rwp_pkg::PH_ERROR;
							end else begin
								cmd.fmt_clear = 1'b1;
								ph_nx         = rwp_pkg::PH_FMT_BODY;
							end
						end else if (st.len_nz) begin
							ph_nx = rwp_pkg::PH_SKIP_FMT;
						end
					end
				end
				rwp_pkg::PH_SKIP_FMT: begin
					cmd.skip = 1'b1;
					if (st.cl_one) begin
						ph_nx = rwp_pkg::PH_FMT_HDR;
					end
				end
				rwp_pkg::PH_FMT_BODY,
				rwp_pkg::PH_FMT_EXTRA: begin
					if (ph == rwp_pkg::PH_FMT_BODY) begin
						cmd.fmt_body = 1'b1;
					end else begin
						cmd.skip = 1'b1;
					end
					if (ph == rwp_pkg::PH_FMT_BODY && st.body_done && !st.tag_ok) begin
						cmd.emit = 1'b1;
						cmd.kind = rwp_pkg::KIND_ERROR;
						cmd.code = rwp_pkg::ERR_PCM;
						ph_nx    = rwp_pkg::PH_ERROR;
					end else if ((ph == rwp_pkg::PH_FMT_BODY && st.body_done && st.cl_is16)
						|| (ph == rwp_pkg::PH_FMT_EXTRA && st.cl_one)) begin
						// end of fmt chunk: bits first, then alignment
						if (!st.bits_ok) begin
							cmd.emit = 1'b1;
							cmd.kind = rwp_pkg::KIND_ERROR;
							cmd.code = rwp_pkg::ERR_BITS;
							ph_nx    = rwp_pkg::PH_ERROR;
						end else if (!st.align_ok) begin
							cmd.emit = 1'b1;
							cmd.kind = rwp_pkg::KIND_ERROR;
							cmd.code = rwp_pkg::ERR_ALIGN;
							ph_nx    = rwp_pkg::PH_ERROR;
						end else begin
							ph_nx = rwp_pkg::PH_DATA_HDR;
						end
					end else if (ph == rwp_pkg::PH_FMT_BODY && st.body_done) begin
						ph_nx = rwp_pkg::PH_FMT_EXTRA;
					end
				end
				rwp_pkg::PH_DATA_HDR: begin
					cmd.hdr = 1'b1;
					if (st.hdr_done) begin
						if (st.id_data) begin
							cmd.div_start = 1'b1;
							ph_nx         = rwp_pkg::PH_DIV_WAIT;
						end else if (st.len_nz) begin
							ph_nx = rwp_pkg::PH_SKIP_DATA;
						end
					end
				end
				rwp_pkg::PH_SKIP_DATA: begin
					cmd.skip = 1'b1;
					if (st.cl_one) begin
						ph_nx = rwp_pkg::PH_DATA_HDR;
					end
				end
				rwp_pkg::PH_SAMPLES: begin
					cmd.sample = 1'b1;
					if (st.samp_emit) begin
						cmd.emit = 1'b1;
						cmd.kind = rwp_pkg::KIND_SAMPLE;
					end
					if (st.data_last) begin
						ph_nx = rwp_pkg::PH_END;
					end
				end
				rwp_pkg::PH_END: begin
					cmd.emit = 1'b1;
					cmd.kind = rwp_pkg::KIND_END;
					ph_nx    = rwp_pkg::PH_IDLE;
				end
				default: ;
			endcase
		end else if (ph_q == rwp_pkg::PH_DIV_WAIT && !st.div_busy && out_free) begin
			cmd.emit = 1'b1;
			if (st.rem_zero) begin
				cmd.kind      = rwp_pkg::KIND_FORMAT;
				cmd.load_data = 1'b1;
				ph_nx         = st.cl_nz ? rwp_pkg::PH_SAMPLES : rwp_pkg::PH_END;
			end else begin
				cmd.kind = rwp_pkg::KIND_ERROR;
				cmd.code = rwp_pkg::ERR_DSIZE;
				ph_nx    = rwp_pkg::PH_ERROR;
			end
		end
	end

endmodule
